[sv/rep_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rep_pkg: shared types and constants of the rANS encoder
// Sequencer states, divider status group, field widths and register codes.
// ----------------------------------------------------------------------------
package rep_pkg;

  localparam int StateW = 64;
  localparam int WordW  = 32;
  localparam int StartW = 24;
  localparam int FreqW  = 25;
  localparam int PrecW  = 5;

  localparam logic [StateW-1:0] StateReset = 64'h0000_0000_8000_0000;

  // configuration register indexes
  localparam logic CFG_PRECISION = 1'b0;
  localparam logic CFG_ESCAPE    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FLUSH_HI,
    ST_FLUSH_LO
  } rep_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

[sv/rep_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rep_div: iterative restoring divider
// Divides the 64-bit coder state by a 25-bit frequency, one quotient bit per
// cycle. Done pulses for one cycle once quotient and remainder are final.
// ----------------------------------------------------------------------------
module rep_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rep_pkg::StateW-1:0]  dividend,
  input  wire logic [rep_pkg::FreqW-1:0]   divisor,
  output rep_pkg::div_stat_t               stat,
  output logic      [rep_pkg::StateW-1:0]  quotient,
  output logic      [rep_pkg::FreqW-1:0]   remainder
);
  import rep_pkg::*;

  localparam int CntW = $clog2(StateW);
  localparam logic [CntW-1:0] LastCnt = CntW'(StateW - 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [StateW-1:0] quo_r, quo_nxt;
  logic [FreqW-1:0]  rem_r, rem_nxt;

  logic [FreqW:0] trial;
  logic [FreqW:0] diff;
  logic           ge;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[StateW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  // sequence the iterations
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[StateW-2:0], ge};
      rem_nxt = ge ? diff[FreqW-1:0] : trial[FreqW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LastCnt) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

[sv/rans_encoder_push.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rans_encoder_push: rANS encoder core, 64-bit state, 32-bit renormalization
// Pushes code one interval each through a single bit-serial divider; flushes
// emit the state as two words and put it back to two to the 31st.
// ----------------------------------------------------------------------------
// Sequence: a push runs the renormalization check, the divider iterations
//   (one quotient bit per cycle) and the state update on divider done; a
//   renorm word is registered at the check, which holds while the output
//   word waits. A flush emits two words, high then low. The input is ready
//   only in idle, so no push or flush is taken before the last is through.
// Throughput: a zero-frequency push per cycle; such a push is dropped.
// Reset: rst_n synchronous, active low; state 2^31, precision 16, escape 4.
// ----------------------------------------------------------------------------
module rans_encoder_push #(
  parameter int MAX_PRECISION = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: interval_start[23:0], interval_freq[48:24], zero pad[55:49]
  input  wire logic [55:0] in_tdata,
  // in_tuser: op[0], use_escape[1]
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: word[31:0]
  output logic      [31:0] out_tdata,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data
);
  import rep_pkg::*;

  localparam logic [PrecW-1:0] MaxPrec = PrecW'(MAX_PRECISION);
  localparam logic [5:0]       ShiftTop = 6'd63;

  rep_state_t state_r, state_nxt;

  logic [PrecW-1:0]  precision_r, escape_r;
  logic [StateW-1:0] coder_state_r, coder_state_nxt;
  logic [StartW-1:0] start_r;
  logic [FreqW-1:0]  freq_r;
  logic [PrecW-1:0]  p_r;

  logic             out_valid_r, out_valid_nxt;
  logic [WordW-1:0] out_word_r, out_word_nxt;
  logic             out_last_r, out_last_nxt;

  logic in_acc, cfg_acc, out_free;
  logic in_op, in_esc;
  logic [StartW-1:0] in_start;
  logic [FreqW-1:0]  in_freq;
  logic [PrecW-1:0]  p_sel, p_sat;
  logic              renorm;
  logic              div_start;
  logic [StateW-1:0] div_dividend;
  div_stat_t         div_stat;
  logic [StateW-1:0] div_quo;
  logic [FreqW-1:0]  div_rem;

  // unpack the input transaction
  assign in_start = in_tdata[StartW-1:0];
  assign in_freq  = in_tdata[StartW+FreqW-1:StartW];
  assign in_op    = in_tuser[0];
  assign in_esc   = in_tuser[1];

  assign in_acc   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign out_free = !out_valid_r || out_tready;

  // select and saturate the precision
  assign p_sel = in_esc ? escape_r : precision_r;
  assign p_sat = (p_sel > MaxPrec) ? MaxPrec : p_sel;

  // limit test against freq * 2^(63-p) at full width
  assign renorm = ((coder_state_r >> (ShiftTop - {1'b0, p_r})) >= {39'd0, freq_r});

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precision_r <= 5'd16;
      escape_r    <= 5'd4;
    end else if (cfg_acc) begin
      case (cfg_index)
        CFG_PRECISION: precision_r <= cfg_data;
        CFG_ESCAPE:    escape_r    <= cfg_data;
        default:       ;
      endcase
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      coder_state_r <= StateReset;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      coder_state_r <= coder_state_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
    if (in_acc) begin
      start_r <= in_start;
      freq_r  <= in_freq;
      p_r     <= p_sat;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op) begin
            state_nxt = ST_FLUSH_HI;
          end else if (in_freq != '0) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (!renorm || out_free) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH_HI: begin
        if (out_free) begin
          state_nxt = ST_FLUSH_LO;
        end
      end
      ST_FLUSH_LO: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready       = 1'b0;
    div_start       = 1'b0;
    div_dividend    = coder_state_r;
    coder_state_nxt = coder_state_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_word_nxt    = out_word_r;
    out_last_nxt    = out_last_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_CHECK: begin
        if (renorm) begin
          // emit the low word, shift the state down
          div_dividend = {32'd0, coder_state_r[StateW-1:WordW]};
          if (out_free) begin
            div_start       = 1'b1;
            coder_state_nxt = div_dividend;
            out_valid_nxt   = 1'b1;
            out_word_nxt    = coder_state_r[WordW-1:0];
            out_last_nxt    = 1'b1;
          end
        end else begin
          div_start = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          coder_state_nxt = (div_quo << p_r) + {39'd0, div_rem} + {40'd0, start_r};
        end
      end
      ST_FLUSH_HI: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = coder_state_r[StateW-1:WordW];
          out_last_nxt  = 1'b0;
        end
      end
      ST_FLUSH_LO: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_word_nxt    = coder_state_r[WordW-1:0];
          out_last_nxt    = 1'b1;
          coder_state_nxt = StateReset;
        end
      end
      default: ;
    endcase
  end

  // single bit-serial divider
  rep_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (freq_r),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign out_tdata  = out_word_r;
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

  // the block never takes a transaction while the divider runs
  a_ready_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  // waiting for the quotient means the divider is running or just finished
  a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("sequencer waits on an idle divider");

  // a divider start comes only from the check step
  a_start_check: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (state_r == ST_CHECK))
    else $error("divider started outside the check step");

  // the final flush word puts the state back to its reset value
  a_flush_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH_LO && out_free) |=> (coder_state_r == StateReset))
    else $error("flush did not reset the coder state");

endmodule
`default_nettype wire
